### rtl/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg
// Shared widths, types and register codes of the curvature speed limiter.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int SPEED_FRAC_BITS = 8;
  localparam int SPEED_W = 16;
  localparam int ACC_W = 12;
  localparam int CURV_W = 18;
  localparam int MAG_W = 17;
  localparam int CFG_W = 17;
  localparam int NUM_SHIFT = 8 + 2 * SPEED_FRAC_BITS;
  localparam int NUM_W = ACC_W + NUM_SHIFT;   // always even
  localparam int REM_W = MAG_W + 1;
  localparam int SQ_W = NUM_W / 2;
  localparam int SR_W = SQ_W + 2;

  typedef enum logic [1:0] {
    REG_TOP_SPEED = 2'd0,
    REG_CAP_SPEED = 2'd1,
    REG_LAT_ACCEL = 2'd2,
    REG_MIN_CURV  = 2'd3
  } reg_idx_t;

  // values carried alongside the divider and root
  typedef struct packed {
    logic               apply;
    logic [SPEED_W-1:0] vbase;
    logic [SPEED_W-1:0] seg_max;
    logic [SPEED_W-1:0] seg_min;
  } side_t;

  typedef struct packed {
    logic             vld;
    side_t            side;
    logic [MAG_W-1:0] mag;
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] q;
  } div_stg_t;

  typedef struct packed {
    logic             vld;
    side_t            side;
    logic [NUM_W-1:0] x;
    logic [SR_W-1:0]  rem;
    logic [SQ_W-1:0]  root;
  } sq_stg_t;

endpackage

### rtl/csl_div.sv
// ----------------------------------------------------------------------------
// csl_div
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module csl_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  csl_pkg::div_stg_t  in_stg,
  output csl_pkg::div_stg_t  out_stg
);

  localparam int N = csl_pkg::NUM_W;

  csl_pkg::div_stg_t stg_r [N];
  csl_pkg::div_stg_t src   [N];
  csl_pkg::div_stg_t stg_nxt [N];

  assign src[0] = in_stg;
  for (genvar g = 1; g < N; g++) begin : g_src
    assign src[g] = stg_r[g-1];
  end

  always_comb begin
    logic [csl_pkg::REM_W-1:0] sh;
    for (int i = 0; i < N; i++) begin
      stg_nxt[i] = src[i];
      sh = {src[i].rem[csl_pkg::REM_W-2:0], src[i].num[N-1]};
      if (sh >= {1'b0, src[i].mag}) begin
        stg_nxt[i].rem = sh - {1'b0, src[i].mag};
        stg_nxt[i].q   = {src[i].q[N-2:0], 1'b1};
      end else begin
        stg_nxt[i].rem = sh;
        stg_nxt[i].q   = {src[i].q[N-2:0], 1'b0};
      end
      stg_nxt[i].num = {src[i].num[N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (!rst_n) begin
        stg_r[i].vld <= 1'b0;
      end else if (en) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign out_stg = stg_r[N-1];

endmodule

### rtl/csl_sqrt.sv
// ----------------------------------------------------------------------------
// csl_sqrt
// Digit-by-digit integer square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module csl_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  csl_pkg::sq_stg_t  in_stg,
  output csl_pkg::sq_stg_t  out_stg
);

  localparam int S = csl_pkg::SQ_W;
  localparam int N = csl_pkg::NUM_W;
  localparam int R = csl_pkg::SR_W;

  csl_pkg::sq_stg_t stg_r [S];
  csl_pkg::sq_stg_t src   [S];
  csl_pkg::sq_stg_t stg_nxt [S];

  assign src[0] = in_stg;
  for (genvar g = 1; g < S; g++) begin : g_src
    assign src[g] = stg_r[g-1];
  end

  always_comb begin
    logic [R-1:0] sh;
    logic [R-1:0] trial;
    for (int i = 0; i < S; i++) begin
      stg_nxt[i] = src[i];
      sh    = {src[i].rem[R-3:0], src[i].x[N-1:N-2]};
      trial = {src[i].root, 2'b01};
      if (sh >= trial) begin
        stg_nxt[i].rem  = sh - trial;
        stg_nxt[i].root = {src[i].root[S-2:0], 1'b1};
      end else begin
        stg_nxt[i].rem  = sh;
        stg_nxt[i].root = {src[i].root[S-2:0], 1'b0};
      end
      stg_nxt[i].x = {src[i].x[N-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < S; i++) begin
      if (!rst_n) begin
        stg_r[i].vld <= 1'b0;
      end else if (en) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign out_stg = stg_r[S-1];

endmodule

### rtl/curvature_speed_limiter.sv
// ----------------------------------------------------------------------------
// curvature_speed_limiter
// Speed band of one path waypoint from curvature and segment limits.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  in_     | input     | curvature, seg_max_speed, seg_min_speed
//  out_    | output    | max_speed_out, min_speed_out
//  cfg_    | input     | write enable, index, data
//
// One waypoint per cycle unless the output stalls. At 8 fraction bits the pipeline
// holds 36 divider stages, 18 root stages and one output register.
// Reset clears the valid bits and loads the register defaults.
// A stall on out_ready freezes the whole pipeline; in_ready drops with it.
// ----------------------------------------------------------------------------
module curvature_speed_limiter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [17:0]          in_curvature,
  input  logic [15:0]                 in_seg_max_speed,
  input  logic [15:0]                 in_seg_min_speed,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_max_speed_out,
  output logic [15:0]                 out_min_speed_out,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [csl_pkg::CFG_W-1:0]   cfg_data
);

  localparam int SW = csl_pkg::SPEED_W;
  localparam int LW = csl_pkg::SQ_W + SW;

  logic [SW-1:0]                top_speed_r;
  logic [SW-1:0]                cap_speed_r;
  logic [csl_pkg::ACC_W-1:0]    lat_accel_r;
  logic [csl_pkg::MAG_W-1:0]    min_curv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_speed_r <= SW'(3433);
      cap_speed_r <= SW'(3433);
      lat_accel_r <= csl_pkg::ACC_W'(512);
      min_curv_r  <= csl_pkg::MAG_W'(66);
    end else if (cfg_we) begin
      case (csl_pkg::reg_idx_t'(cfg_index))
        csl_pkg::REG_TOP_SPEED: top_speed_r <= cfg_data[SW-1:0];
        csl_pkg::REG_CAP_SPEED: cap_speed_r <= cfg_data[SW-1:0];
        csl_pkg::REG_LAT_ACCEL: lat_accel_r <= cfg_data[csl_pkg::ACC_W-1:0];
        csl_pkg::REG_MIN_CURV:  min_curv_r  <= cfg_data[csl_pkg::MAG_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  logic [SW-1:0] max_r, min_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // entry: magnitude, law enable, numerator
  logic [18:0]               neg_mag;
  logic [18:0]               mag_full;
  logic [csl_pkg::MAG_W-1:0] mag;
  csl_pkg::div_stg_t         div_in, div_out;
  csl_pkg::sq_stg_t          sq_in, sq_out;

  always_comb begin
    neg_mag  = 19'd0 - {in_curvature[17], in_curvature};
    mag_full = in_curvature[17] ? neg_mag : {1'b0, in_curvature};
    mag      = (mag_full > 19'd65536) ? csl_pkg::MAG_W'(65536)
                                      : mag_full[csl_pkg::MAG_W-1:0];
    div_in.vld          = in_valid;
    div_in.side.apply   = (mag != '0) && (mag > min_curv_r);
    div_in.side.vbase   = (cap_speed_r < top_speed_r) ? cap_speed_r : top_speed_r;
    div_in.side.seg_max = in_seg_max_speed;
    div_in.side.seg_min = in_seg_min_speed;
    div_in.mag          = mag;
    div_in.rem          = '0;
    div_in.num          = csl_pkg::NUM_W'(lat_accel_r) << csl_pkg::NUM_SHIFT;
    div_in.q            = '0;
  end

  csl_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .in_stg(div_in), .out_stg(div_out)
  );

  always_comb begin
    sq_in.vld  = div_out.vld;
    sq_in.side = div_out.side;
    sq_in.x    = div_out.q;
    sq_in.rem  = '0;
    sq_in.root = '0;
  end

  csl_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en), .in_stg(sq_in), .out_stg(sq_out)
  );

  logic [LW-1:0] law_w;
  logic [SW-1:0] law, vmax, vmin;

  always_comb begin
    law_w = LW'(sq_out.root);
    law   = (law_w > LW'(16'hFFFF)) ? 16'hFFFF : law_w[SW-1:0];
    vmax  = sq_out.side.vbase;
    if (sq_out.side.apply && (law < vmax)) vmax = law;
    if ((sq_out.side.seg_max != '0) && (sq_out.side.seg_max < vmax)) begin
      vmax = sq_out.side.seg_max;
    end
    vmin = sq_out.side.seg_min;
    if (vmin > vmax) vmin = vmax;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      max_r <= vmax;
      min_r <= vmin;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_max_speed_out = max_r;
  assign out_min_speed_out = min_r;

`ifndef SYNTHESIS
  a_band_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_min_speed_out <= out_max_speed_out))
    else $error("lower limit above upper limit");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken during output stall");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_out.vld && !en) |=> sq_out.vld)
    else $error("pipeline item lost during stall");
`endif

endmodule

### tb/curvature_speed_limiter_tb.sv
// ----------------------------------------------------------------------------
// curvature_speed_limiter_tb
// Drives waypoints through the speed limiter and checks each speed band
// against a predictor of the curvature law and the segment limits, across
// several register settings, idle patterns and a long output back-pressure.
// ----------------------------------------------------------------------------
module curvature_speed_limiter_tb;

  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [15:0] vmax;
    logic [15:0] vmin;
  } band_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic signed [17:0]            in_curvature;
  logic [15:0]                   in_seg_max_speed;
  logic [15:0]                   in_seg_min_speed;
  logic                          out_valid;
  logic                          out_ready;
  logic [15:0]                   out_max_speed_out;
  logic [15:0]                   out_min_speed_out;
  logic                          cfg_we;
  logic [1:0]                    cfg_index;
  logic [csl_pkg::CFG_W-1:0]     cfg_data;

  // predictor copy of the registers
  logic [15:0] top_speed_q;
  logic [15:0] cap_speed_q;
  logic [11:0] lat_accel_q;
  logic [16:0] min_curv_q;

  band_t band_q[$];
  int    errors;
  int    send_idle_pct;
  int    recv_stall_pct;
  int    hold_cycles;
  int    cycles;

  curvature_speed_limiter u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_curvature      (in_curvature),
    .in_seg_max_speed  (in_seg_max_speed),
    .in_seg_min_speed  (in_seg_min_speed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_max_speed_out (out_max_speed_out),
    .out_min_speed_out (out_min_speed_out),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("curvature_speed_limiter_tb: errors");
      $finish;
    end
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic band_t speed_band(input logic signed [17:0] curv,
                                       input logic [15:0] seg_max,
                                       input logic [15:0] seg_min);
    logic [17:0] mag;
    logic [63:0] law;
    band_t b;
    mag = curv[17] ? 18'(-curv) : 18'(curv);
    if (mag > 18'd65536) mag = 18'd65536;
    b.vmax = (cap_speed_q < top_speed_q) ? cap_speed_q : top_speed_q;
    b.vmin = 16'd0;
    if (mag != 0 && mag > min_curv_q) begin
      law = floor_sqrt((64'(lat_accel_q) << (8 + 2 * csl_pkg::SPEED_FRAC_BITS))
                       / 64'(mag));
      if (law > 64'hFFFF) law = 64'hFFFF;
      if (law[15:0] < b.vmax) b.vmax = law[15:0];
    end
    if (seg_max != 0 && seg_max < b.vmax) b.vmax = seg_max;
    if (seg_min != 0) b.vmin = seg_min;
    if (b.vmin > b.vmax) b.vmin = b.vmax;
    return b;
  endfunction

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    band_t want;
    if (rst_n && out_valid && out_ready) begin
      if (band_q.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10)
          $display("unexpected result: max %0d min %0d", out_max_speed_out,
                   out_min_speed_out);
      end else begin
        want = band_q.pop_front();
        if (out_max_speed_out !== want.vmax || out_min_speed_out !== want.vmin) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("mismatch: expected max %0d min %0d, got max %0d min %0d",
                     want.vmax, want.vmin, out_max_speed_out, out_min_speed_out);
        end
      end
    end
  end

  task automatic send_waypoint(input logic signed [17:0] curv,
                               input logic [15:0] seg_max,
                               input logic [15:0] seg_min);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_curvature = curv;
    in_seg_max_speed = seg_max;
    in_seg_min_speed = seg_min;
    do @(posedge clk); while (!in_ready);
    band_q = {band_q, speed_band(curv, seg_max, seg_min)};
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (band_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input csl_pkg::reg_idx_t idx,
                           input logic [csl_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      csl_pkg::REG_TOP_SPEED: top_speed_q = val[15:0];
      csl_pkg::REG_CAP_SPEED: cap_speed_q = val[15:0];
      csl_pkg::REG_LAT_ACCEL: lat_accel_q = val[11:0];
      csl_pkg::REG_MIN_CURV:  min_curv_q  = val[16:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] top, input logic [15:0] cap,
                            input logic [11:0] acc, input logic [16:0] kmin);
    drain();
    write_reg(csl_pkg::REG_TOP_SPEED, csl_pkg::CFG_W'(top));
    write_reg(csl_pkg::REG_CAP_SPEED, csl_pkg::CFG_W'(cap));
    write_reg(csl_pkg::REG_LAT_ACCEL, csl_pkg::CFG_W'(acc));
    write_reg(csl_pkg::REG_MIN_CURV, kmin);
  endtask

  function automatic logic signed [17:0] pick_curvature();
    logic [17:0] m;
    case ($urandom_range(4))
      0: return 18'($urandom);
      1: m = 18'($urandom_range(2000));
      2: m = 18'(min_curv_q) + 18'($urandom_range(4)) - 18'd2;
      3: m = 18'($urandom_range(65536));
      default: m = 18'($urandom_range(3));
    endcase
    return $urandom_range(1) ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [15:0] pick_speed();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'($urandom);
      default: return 16'($urandom_range(4000));
    endcase
  endfunction

  task automatic send_random(input int n);
    repeat (n) send_waypoint(pick_curvature(), pick_speed(), pick_speed());
  endtask

  task automatic test_directed();
    send_waypoint(18'sd0, 16'd0, 16'd0);
    send_waypoint(18'sd1, 16'd0, 16'd0);
    send_waypoint(-18'sd1, 16'd0, 16'd0);
    send_waypoint(18'sd66, 16'd0, 16'd0);
    send_waypoint(18'sd67, 16'd0, 16'd0);
    send_waypoint(-18'sd67, 16'd0, 16'd0);
    send_waypoint(18'sd65536, 16'd0, 16'd0);
    send_waypoint(-18'sd65536, 16'd0, 16'd0);
    send_waypoint(18'sh20000, 16'd0, 16'd0);       // most negative pattern
    send_waypoint(18'sh1FFFF, 16'd0, 16'd0);       // beyond saturation
    send_waypoint(18'sh3FFFF, 16'hFFFF, 16'hFFFF);
    send_waypoint(18'sd500, 16'd100, 16'd50);
    send_waypoint(18'sd500, 16'd100, 16'd200);     // min clamped to max
    send_waypoint(18'sd0, 16'd1, 16'd0);
    send_waypoint(18'sd0, 16'd0, 16'd1);
    send_waypoint(18'sd0, 16'hFFFF, 16'd0);
    send_waypoint(18'sd0, 16'h5555, 16'hAAAA);
    send_waypoint(-18'sd2000, 16'hAAAA, 16'h5555);
  endtask

  task automatic test_register_extremes();
    set_limits(16'hFFFF, 16'hFFFF, 12'hFFF, 17'd0);   // law active even at |k|=1
    send_waypoint(18'sd0, 16'd0, 16'd0);
    send_waypoint(18'sd1, 16'd0, 16'd0);
    send_waypoint(-18'sd65536, 16'd0, 16'd0);
    send_random(120);
    set_limits(16'd0, 16'hFFFF, 12'd0, 17'd0);
    send_random(60);
    set_limits(16'hFFFF, 16'd0, 12'd0, 17'd0);
    send_random(60);
    set_limits(16'hFFFF, 16'hFFFF, 12'd0, 17'd1);     // zero acceleration
    send_random(100);
    set_limits(16'hFFFF, 16'hFFFF, 12'hFFF, 17'd65536);
    send_waypoint(-18'sd65536, 16'd0, 16'd0);
    send_random(60);
    set_limits(16'h1234, 16'hFFFF, 12'h800, 17'h1FFFF);
    send_random(60);
    set_limits(16'hFFFF, 16'd3000, 12'h0AB, 17'd10);
    send_random(150);
  endtask

  task automatic test_idle_patterns();
    set_limits(16'd3433, 16'd3433, 12'd512, 17'd66);
    send_idle_pct = 10;
    recv_stall_pct = 59;
    send_random(400);
    send_idle_pct = 59;
    recv_stall_pct = 10;
    send_random(350);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(300);
  endtask

  task automatic test_backpressure();
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 30;
    @(negedge clk);
    hold_cycles = 400;
    send_random(220);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_curvature = '0;
    in_seg_max_speed = '0;
    in_seg_min_speed = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = csl_pkg::REG_TOP_SPEED;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    top_speed_q = 16'd3433;
    cap_speed_q = 16'd3433;
    lat_accel_q = 12'd512;
    min_curv_q = 17'd66;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_register_extremes();
    test_idle_patterns();
    test_backpressure();
    drain();

    if (errors == 0) begin
      $display("curvature_speed_limiter_tb: clean");
    end else begin
      $display("curvature_speed_limiter_tb: errors");
    end
    $finish;
  end

endmodule
